FILE: hdl/dtkm_pkg.sv
// Shared types and constants for the dedup top-K merge core.
// Holds the controller/datapath command and status structs and CSR layout.
// No dependencies.
`timescale 1ns / 1ps

package dtkm_pkg;

   localparam int DTKM_TOP_K    = 16;
   localparam int DOC_W         = 32;
   localparam int SCORE_W       = 32;
   localparam int LIMIT_W       = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // CSR layout: one 32-bit register per word
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_IDX_LSB   = 2;
   localparam logic CSR_IDX_RESULT_LIMIT = 1'b0;

   typedef struct packed {
      logic load_hit;
      logic do_remove;
      logic do_insert;
      logic latch_count;
      logic emit_entry;
      logic emit_marker;
      logic clear_list;
   } dtkm_cmd_type;

   typedef struct packed {
      logic hit_failed;
      logic hit_last;
      logic match_found;
      logic match_lower;
      logic remaining_zero;
      logic remaining_one;
      logic out_free;
   } dtkm_status_type;

endpackage

FILE: hdl/dtkm_datapath.sv
// Datapath of the dedup top-K merge: hit register, sorted entry list,
// emit counter and the output register. Depends on dtkm_pkg.
`timescale 1ns / 1ps

module dtkm_datapath
   import dtkm_pkg::*;
#(
   parameter int TOP_K = DTKM_TOP_K
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dtkm_cmd_type              cmd,
   output dtkm_status_type           status,
   input  logic [LIMIT_W-1:0]        result_limit,
   input  logic [DOC_W-1:0]          req_doc_id,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic                      req_shard_failed,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DOC_W-1:0]          rsp_result_doc,
   output logic signed [SCORE_W-1:0] rsp_result_score,
   output logic                      rsp_none_found,
   output logic                      rsp_final_result
);

   localparam int CW = $clog2(TOP_K + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   // hit under work
   logic [DOC_W-1:0]          hit_doc_ff;
   logic signed [SCORE_W-1:0] hit_score_ff;
   logic                      hit_failed_ff;
   logic                      hit_last_ff;

   // sorted entry list
   logic [DOC_W-1:0]          doc_ff   [TOP_K];
   logic [DOC_W-1:0]          doc_in   [TOP_K];
   logic signed [SCORE_W-1:0] score_ff [TOP_K];
   logic signed [SCORE_W-1:0] score_in [TOP_K];
   logic [TOP_K-1:0]          used_ff;
   logic [TOP_K-1:0]          used_in;

   logic [TOP_K-1:0]          match;
   logic [TOP_K-1:0]          higher;
   logic [TOP_K-1:0]          ge;
   logic [TOP_K:0]            ge_prev;
   logic [TOP_K-1:0]          at_or_after;
   logic [TOP_K-1:0]          boundary;
   logic [TOP_K:0]            used_ext;

   logic [CW-1:0]             used_count;
   logic [CW-1:0]             remaining_ff;
   logic [CW-1:0]             remaining_in;
   logic [LW-1:0]             limit_ext;
   logic [LW-1:0]             count_ext;
   logic [LW-1:0]             lim_clamped;
   logic [LW-1:0]             emit_count;

   logic                      rsp_valid_ff;
   logic [DOC_W-1:0]          rsp_doc_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                      rsp_none_ff;
   logic                      rsp_final_ff;

   assign ge_prev  = {ge, 1'b1};
   assign used_ext = {1'b0, used_ff};
   assign boundary = used_ff & ~used_ext[TOP_K:1];

   genvar gi;
   generate
      for (gi = 0; gi < TOP_K; gi++) begin : g_entry
         logic [DOC_W-1:0]          prv_doc;
         logic signed [SCORE_W-1:0] prv_score;
         logic                      prv_used;
         logic [DOC_W-1:0]          nxt_doc;
         logic signed [SCORE_W-1:0] nxt_score;
         logic                      nxt_used;
         logic                      shift_up;
         logic                      take_new;
         logic                      take_prev;

         if (gi == 0) begin : g_head
            assign prv_doc   = '0;
            assign prv_score = '0;
            assign prv_used  = 1'b0;
         end else begin : g_body
            assign prv_doc   = doc_ff[gi-1];
            assign prv_score = score_ff[gi-1];
            assign prv_used  = used_ff[gi-1];
         end

         if (gi == TOP_K - 1) begin : g_tail
            assign nxt_doc   = '0;
            assign nxt_score = '0;
            assign nxt_used  = 1'b0;
         end else begin : g_inner
            assign nxt_doc   = doc_ff[gi+1];
            assign nxt_score = score_ff[gi+1];
            assign nxt_used  = used_ff[gi+1];
         end

         assign match[gi]  = used_ff[gi] && (doc_ff[gi] == hit_doc_ff);
         assign higher[gi] = hit_score_ff > score_ff[gi];
         assign ge[gi]     = used_ff[gi] && (score_ff[gi] >= hit_score_ff);
         assign at_or_after[gi] =
            |(match & ({TOP_K{1'b1}} >> (TOP_K - 1 - gi)));

         // close the gap left by a removed or emitted entry
         assign shift_up  = cmd.emit_entry | (cmd.do_remove & at_or_after[gi]);
         assign take_new  = cmd.do_insert & ~ge[gi] & ge_prev[gi];
         assign take_prev = cmd.do_insert & ~ge[gi] & ~ge_prev[gi];

         assign doc_in[gi]   = shift_up  ? nxt_doc   :
                               take_new  ? hit_doc_ff :
                               take_prev ? prv_doc   : doc_ff[gi];
         assign score_in[gi] = shift_up  ? nxt_score :
                               take_new  ? hit_score_ff :
                               take_prev ? prv_score : score_ff[gi];
         assign used_in[gi]  = cmd.clear_list ? 1'b0     :
                               shift_up       ? nxt_used :
                               take_new       ? 1'b1     :
                               take_prev      ? prv_used : used_ff[gi];
      end
   endgenerate

   // used entries form a prefix, so the count is where the ones end
   always_comb begin
      used_count = '0;
      for (int i = 0; i < TOP_K; i++) begin
         if (boundary[i]) begin
            used_count = used_count | CW'(i + 1);
         end
      end
   end

   assign limit_ext   = LW'(result_limit);
   assign count_ext   = LW'(used_count);
   assign lim_clamped = (limit_ext > LW'(TOP_K)) ? LW'(TOP_K) : limit_ext;
   assign emit_count  = (count_ext < lim_clamped) ? count_ext : lim_clamped;

   always_comb begin
      remaining_in = remaining_ff;
      if (cmd.latch_count) begin
         remaining_in = emit_count[CW-1:0];
      end else if (cmd.emit_entry) begin
         remaining_in = remaining_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_hit) begin
         hit_doc_ff    <= req_doc_id;
         hit_score_ff  <= req_score;
         hit_failed_ff <= req_shard_failed;
         hit_last_ff   <= req_last;
      end
      for (int i = 0; i < TOP_K; i++) begin
         doc_ff[i]   <= doc_in[i];
         score_ff[i] <= score_in[i];
      end
      if (cmd.emit_entry || cmd.emit_marker) begin
         rsp_doc_ff   <= cmd.emit_marker ? '0 : doc_ff[0];
         rsp_score_ff <= cmd.emit_marker ? '0 : score_ff[0];
         rsp_none_ff  <= cmd.emit_marker;
         rsp_final_ff <= cmd.emit_marker | (remaining_ff == CW'(1));
      end
      if (reset) begin
         used_ff      <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         remaining_ff <= remaining_in;
         if (cmd.emit_entry || cmd.emit_marker) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.hit_failed     = hit_failed_ff;
   assign status.hit_last       = hit_last_ff;
   assign status.match_found    = |match;
   assign status.match_lower    = |(match & ~higher);
   assign status.remaining_zero = (remaining_ff == '0);
   assign status.remaining_one  = (remaining_ff == CW'(1));
   assign status.out_free       = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_doc   = rsp_doc_ff;
   assign rsp_result_score = rsp_score_ff;
   assign rsp_none_found   = rsp_none_ff;
   assign rsp_final_result = rsp_final_ff;

   a_used_prefix : assert property (@(posedge clock) disable iff (reset)
      (used_ff & (used_ff + 1'b1)) == '0)
      else $error("entry list has a hole");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("document kept twice");

   a_emit_into_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_entry || cmd.emit_marker) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output overwritten while stalled");

   a_remaining_bound : assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= CW'(TOP_K))
      else $error("emit count above list depth");

endmodule

FILE: hdl/dtkm_ctrl.sv
// Controller of the dedup top-K merge: sequences match, insert and emit
// steps for one request at a time. Depends on dtkm_pkg.
`timescale 1ns / 1ps

module dtkm_ctrl
   import dtkm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output dtkm_cmd_type    cmd,
   input  dtkm_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_INSERT,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_hit = 1'b1;
               state_in     = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (status.hit_failed || (status.match_found && status.match_lower)) begin
               state_in = status.hit_last ? ST_PREP : ST_IDLE;
            end else begin
               cmd.do_remove = status.match_found;
               state_in      = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.do_insert = 1'b1;
            state_in      = status.hit_last ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.latch_count = 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (status.remaining_zero) begin
                  cmd.emit_marker = 1'b1;
                  cmd.clear_list  = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.emit_entry = 1'b1;
                  if (status.remaining_one) begin
                     cmd.clear_list = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: hdl/dedup_top_k_merge_core.sv
// Top level of the dedup top-K merge core: CSR port, controller, datapath.
// Depends on dtkm_pkg, dtkm_ctrl and dtkm_datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   doc_id, score, shard_failed, last
//   rsp      out        rsp_valid/rsp_stall   result_doc, result_score,
//                                             none_found, final_result
//   csr      in/out     psel/penable/pready   paddr, pwdata, prdata
//
// A hit is accepted and matched against all entries; it is ignored if its
// shard failed or it repeats a kept document at no higher score, else any
// older copy is removed and it goes into the sorted list. A last hit then
// fixes the emit count and emits up to TOP_K results (or one empty marker).
// Synchronous reset empties the list; no clearing pass is needed.
// rsp_stall holds the output and pauses emits; req_stall is high while busy.
`timescale 1ns / 1ps

module dedup_top_k_merge_core
   import dtkm_pkg::*;
#(
   parameter int TOP_K = DTKM_TOP_K
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [DOC_W-1:0]          req_doc_id,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic                      req_shard_failed,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DOC_W-1:0]          rsp_result_doc,
   output logic signed [SCORE_W-1:0] rsp_result_score,
   output logic                      rsp_none_found,
   output logic                      rsp_final_result,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   logic [LIMIT_W-1:0] limit_ff;
   dtkm_cmd_type       cmd;
   dtkm_status_type    status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[CSR_IDX_LSB] == CSR_IDX_RESULT_LIMIT)) begin
         limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_IDX_LSB] == CSR_IDX_RESULT_LIMIT) ?
                   {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff} : '0;

   dtkm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dtkm_datapath #(
      .TOP_K (TOP_K)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .result_limit     (limit_ff),
      .req_doc_id       (req_doc_id),
      .req_score        (req_score),
      .req_shard_failed (req_shard_failed),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_doc   (rsp_result_doc),
      .rsp_result_score (rsp_result_score),
      .rsp_none_found   (rsp_none_found),
      .rsp_final_result (rsp_final_result)
   );

endmodule
